/* sv/dcthp_pkg.sv */
// Shared constants and types for the DCT-II high-pass residual block.
package dcthp_pkg;

  localparam int unsigned MAX_FRAMES_DEF   = 64;
  localparam int unsigned COS_DEPTH_DEF    = 256;
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;

  // dimension filter limit
  localparam int unsigned MAX_DIMS    = 64;
  localparam int unsigned DIM_LIMIT_W = 10;

  // field and register widths
  localparam int unsigned DIM_W      = 6;
  localparam int unsigned COMP_W     = 6;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned FRAME_W    = 7;
  localparam int unsigned LOW_W      = 6;
  localparam int unsigned DIM_END_W  = 7;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // register reset values
  localparam logic [FRAME_W-1:0]   FRAME_COUNT_RST = 7'd64;
  localparam logic [LOW_W-1:0]     LOW_COMP_RST    = 6'd0;
  localparam logic [DIM_W-1:0]     FIRST_DIM_RST   = 6'd0;
  localparam logic [DIM_END_W-1:0] DIM_END_RST     = 7'd64;
  localparam logic [SCALE_W-1:0]   SCALE_RST       = 24'd8192;

  // cosine path
  localparam int unsigned COS_W      = 16;  // signed Q1.15
  localparam int unsigned RECIP_BITS = 24;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT  = 3'd0,
    REG_LOW_COMP     = 3'd1,
    REG_FIRST_DIM    = 3'd2,
    REG_DIM_END      = 3'd3,
    REG_OUTPUT_SCALE = 3'd4
  } cfg_reg_t;

  // per-MAC tag traveling with the datapath
  typedef struct packed {
    logic              valid;
    logic              first;  // first sample of a component
    logic              last;   // last sample of a component
    logic              klast;  // component N-1
    logic [COMP_W-1:0] k;
  } tag_t;

endpackage

/* sv/dcthp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dcthp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/dcthp_cos.sv */
// Phase to cosine lookup: reciprocal scaling, quadrant fold and quarter-wave table.
module dcthp_cos #(
  parameter int unsigned MAX_FRAMES      = dcthp_pkg::MAX_FRAMES_DEF,
  parameter int unsigned COS_TABLE_DEPTH = dcthp_pkg::COS_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic [$clog2(4*MAX_FRAMES)-1:0]        phase,
  input  logic [$clog2(MAX_FRAMES+1)-1:0]        frames,
  output logic signed [dcthp_pkg::COS_W-1:0]     cos_val
);
  import dcthp_pkg::*;

  localparam int unsigned FW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PW    = $clog2(4 * MAX_FRAMES);
  localparam int unsigned PRODW = PW + RECIP_BITS;
  localparam int unsigned SCW   = PRODW + $clog2(COS_TABLE_DEPTH) + 1;
  localparam int unsigned PRW2  = SCW - RECIP_BITS;
  localparam int unsigned POSW  = $clog2(4 * COS_TABLE_DEPTH);
  localparam int unsigned TW    = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned IW    = $clog2(COS_TABLE_DEPTH + 1);
  localparam longint unsigned TWO_DEPTH = 2 * COS_TABLE_DEPTH;

  // cos(pi*i/(2*DEPTH)) in Q1.15 by an eleven-term Taylor series in Q2.30
  function automatic logic [COS_W-2:0] cos_entry(input int unsigned idx);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x    = (64'(idx) * PI_Q30 + 64'(COS_TABLE_DEPTH)) / TWO_DEPTH;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    sum  = signed'(term);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      unique case (n)
        1:       term = term / 64'd2;
        2:       term = term / 64'd12;
        3:       term = term / 64'd30;
        4:       term = term / 64'd56;
        5:       term = term / 64'd90;
        6:       term = term / 64'd132;
        7:       term = term / 64'd182;
        8:       term = term / 64'd240;
        9:       term = term / 64'd306;
        default: term = term / 64'd380;
      endcase
      if (n[0]) sum = sum - signed'(term);
      else      sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    v = (64'(sum) + (64'd1 << 14)) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return v[COS_W-2:0];
  endfunction

  logic [COS_W-2:0]      rom [COS_TABLE_DEPTH];
  logic [RECIP_BITS-1:0] recip_rom [2**FW];

  for (genvar i = 0; i < COS_TABLE_DEPTH; i++) begin : g_rom
    assign rom[i] = cos_entry(i);
  end

  // round(2^24 / N) per frame count
  for (genvar i = 0; i < 2**FW; i++) begin : g_recip
    localparam longint unsigned NI = (i < 2) ? 2 : i;
    localparam longint unsigned RV = ((64'd1 << RECIP_BITS) + NI / 2) / NI;
    assign recip_rom[i] = RECIP_BITS'(RV);
  end

  logic [RECIP_BITS-1:0] recip_q;
  logic [PRODW-1:0]      prod_q;
  logic [SCW-1:0]        scaled;
  logic [PRW2-1:0]       pos_raw;
  logic [PRW2-1:0]       pos_red;
  logic [POSW-1:0]       pos;
  logic [POSW-1:0]       r;
  logic                  q_odd;
  logic                  neg;
  logic [IW-1:0]         idx;
  logic                  neg_q;
  logic [IW-1:0]         idx_q;
  logic [COS_W-2:0]      entry;
  logic signed [COS_W-1:0] mag;

  always_comb begin
    scaled  = SCW'(prod_q) * SCW'(COS_TABLE_DEPTH) + (SCW'(1) << (RECIP_BITS - 1));
    pos_raw = scaled[SCW-1:RECIP_BITS];
    pos_red = (pos_raw >= PRW2'(4 * COS_TABLE_DEPTH)) ?
              pos_raw - PRW2'(4 * COS_TABLE_DEPTH) : pos_raw;
    pos     = pos_red[POSW-1:0];
    if (pos >= POSW'(3 * COS_TABLE_DEPTH)) begin
      r = pos - POSW'(3 * COS_TABLE_DEPTH); q_odd = 1'b1; neg = 1'b0;
    end else if (pos >= POSW'(2 * COS_TABLE_DEPTH)) begin
      r = pos - POSW'(2 * COS_TABLE_DEPTH); q_odd = 1'b0; neg = 1'b1;
    end else if (pos >= POSW'(COS_TABLE_DEPTH)) begin
      r = pos - POSW'(COS_TABLE_DEPTH); q_odd = 1'b1; neg = 1'b1;
    end else begin
      r = pos; q_odd = 1'b0; neg = 1'b0;
    end
    idx = q_odd ? IW'(COS_TABLE_DEPTH) - IW'(r) : IW'(r);
  end

  // index DEPTH is the zero crossing
  always_comb begin
    entry = (idx_q == IW'(COS_TABLE_DEPTH)) ? '0 : rom[idx_q[TW-1:0]];
    mag   = signed'(COS_W'(entry));
  end

  always_ff @(posedge clk) begin
    recip_q <= recip_rom[frames];
    prod_q  <= PRODW'(phase) * PRODW'(recip_q);
    neg_q   <= neg;
    idx_q   <= idx;
    cos_val <= neg_q ? -mag : mag;
  end

endmodule

/* sv/dct_highpass_residual_unit.sv */
// Top level of the unnormalized DCT-II high-pass residual block.
//
// Samples arrive one per start request while busy is low; samples whose dimension
// lies outside [first_dim, dim_end) are dropped. Accepted samples go into a sample
// RAM in arrival order. The request that brings the count to N (frame_count,
// clamped to 2..MAX_FRAMES) raises busy and starts the transform: one
// multiply-accumulate pipe reads the RAM one entry per cycle, component by
// component from low_component up to N-1, and busy stays high until the pipe has
// drained; the single sample RAM read port and the one MAC set this pace. Other
// samples are taken without raising busy. Results come out one per component,
// each on the result ports for one cycle with strobe high; the receiver cannot stall
// them, so it must take every strobe. The last result of a series shows up in the
// first cycle after busy falls. If low_component is not below N, the series
// completes with no result and busy stays low. A configuration write is taken at
// any edge with cfg_we high, so write registers only while busy is low and no
// result is still due. The sample RAM is not cleared after reset.
module dct_highpass_residual_unit #(
  parameter int unsigned MAX_FRAMES      = dcthp_pkg::MAX_FRAMES_DEF,
  parameter int unsigned COS_TABLE_DEPTH = dcthp_pkg::COS_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH    = dcthp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [dcthp_pkg::DIM_W-1:0]         dim_index,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  input  logic                                cfg_we,
  input  logic [dcthp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dcthp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                strobe,
  output logic [dcthp_pkg::DIM_W-1:0]         out_dim,
  output logic [dcthp_pkg::COMP_W-1:0]        component,
  output logic signed [dcthp_pkg::COEF_W-1:0] coefficient,
  output logic                                saturated,
  output logic                                last_of_run
);
  import dcthp_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_FRAMES);
  localparam int unsigned FW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PW   = $clog2(4 * MAX_FRAMES);
  localparam int unsigned PRW  = SAMPLE_WIDTH + COS_W;
  localparam int unsigned ACCW = PRW + $clog2(MAX_FRAMES);
  localparam int unsigned A16W = ACCW - 15;
  localparam int unsigned MW   = A16W + SCALE_W + 1;
  localparam int unsigned RESW = MW - 16;
  localparam int unsigned EW   = (RESW > 33) ? RESW : 33;
  localparam logic signed [EW-1:0] SAT_HI = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // configuration registers
  logic [FRAME_W-1:0]   frame_count;
  logic [LOW_W-1:0]     low_component;
  logic [DIM_W-1:0]     first_dim;
  logic [DIM_END_W-1:0] dim_end;
  logic [SCALE_W-1:0]   output_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= FRAME_COUNT_RST;
      low_component <= LOW_COMP_RST;
      first_dim     <= FIRST_DIM_RST;
      dim_end       <= DIM_END_RST;
      output_scale  <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_COUNT:  frame_count   <= cfg_data[FRAME_W-1:0];
        REG_LOW_COMP:     low_component <= cfg_data[LOW_W-1:0];
        REG_FIRST_DIM:    first_dim     <= cfg_data[DIM_W-1:0];
        REG_DIM_END:      dim_end       <= cfg_data[DIM_END_W-1:0];
        REG_OUTPUT_SCALE: output_scale  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // N clamped to the supported range
  logic [FW-1:0] n_cur;
  logic [AW-1:0] nm1;
  logic [PW:0]   four_n;

  always_comb begin
    if (frame_count < FRAME_W'(2))               n_cur = FW'(2);
    else if (frame_count > FRAME_W'(MAX_FRAMES)) n_cur = FW'(MAX_FRAMES);
    else                                         n_cur = FW'(frame_count);
    nm1    = AW'(n_cur - FW'(1));
    four_n = (PW + 1)'(n_cur) << 2;
  end

  // input request handling
  state_t        state;
  logic [FW-1:0] count;
  logic [FW-1:0] cnt_inc;
  logic          accept;
  logic          in_range;
  logic          take;
  logic          complete;
  logic          go;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (dim_index >= first_dim) &&
                    (DIM_END_W'(dim_index) < dim_end) &&
                    (DIM_LIMIT_W'(dim_index) < DIM_LIMIT_W'(MAX_DIMS));
  assign take     = accept && in_range;
  assign cnt_inc  = count + FW'(1);
  assign complete = (cnt_inc >= n_cur);
  assign go       = FRAME_W'(low_component) < FRAME_W'(n_cur);

  // sample store
  logic [AW-1:0]           t;
  logic [SAMPLE_WIDTH-1:0] rdata;

  dcthp_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (take),
    .waddr (count[AW-1:0]),
    .wdata (sample),
    .raddr (t),
    .rdata (rdata)
  );

  // sequencer: t walks samples, k walks components, p tracks k*(2t+1) mod 4N
  logic [AW-1:0] k;
  logic [PW-1:0] p;
  logic [PW:0]   p_sum;
  logic [PW-1:0] p_step;
  logic          t_last;
  logic          k_last;
  tag_t          tag0;
  tag_t          fin3;

  always_comb begin
    t_last     = (t == nm1);
    k_last     = (k == nm1);
    p_sum      = (PW + 1)'(p) + (PW + 1)'({k, 1'b0});
    p_step     = (p_sum >= four_n) ? PW'(p_sum - four_n) : PW'(p_sum);
    tag0.valid = (state == ST_RUN);
    tag0.first = (t == '0);
    tag0.last  = t_last;
    tag0.klast = k_last;
    tag0.k     = COMP_W'(k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      t     <= '0;
      k     <= '0;
      p     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (complete) begin
              count <= '0;
              t     <= '0;
              k     <= AW'(low_component);
              p     <= PW'(low_component);
              if (go) begin
                state <= ST_RUN;
              end
            end else begin
              count <= cnt_inc;
            end
          end
        end
        ST_RUN: begin
          if (t_last) begin
            t <= '0;
            if (k_last) begin
              state <= ST_DRAIN;
            end else begin
              k <= k + AW'(1);
              p <= PW'(k) + PW'(1);
            end
          end else begin
            t <= t + AW'(1);
            p <= p_step;
          end
        end
        ST_DRAIN: begin
          if (fin3.valid && fin3.klast) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // dimension of the completing sample
  always_ff @(posedge clk) begin
    if (take && complete) begin
      out_dim <= dim_index;
    end
  end

  // cosine, with the phase registered as product, then index, then output
  logic signed [COS_W-1:0] cos_q;

  dcthp_cos #(
    .MAX_FRAMES      (MAX_FRAMES),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_cos (
    .clk     (clk),
    .phase   (p),
    .frames  (n_cur),
    .cos_val (cos_q)
  );

  // MAC pipe, samples delayed to line up with the cosine
  tag_t                           tag1, tag2, tag3, tag4;
  tag_t                           fin0, fin1, fin2;
  logic signed [SAMPLE_WIDTH-1:0] x_d1, x_d2;
  logic signed [PRW-1:0]          prod;
  logic signed [ACCW-1:0]         acc;
  logic signed [ACCW-1:0]         acc_plus;
  logic signed [A16W-1:0]         a16;
  logic signed [MW-1:0]           mprod;
  logic signed [MW-1:0]           mplus;
  logic signed [RESW-1:0]         res;
  logic signed [EW-1:0]           res_ext;

  // only the last sample of a component carries a result
  always_comb begin
    fin0       = tag4;
    fin0.valid = tag4.valid && tag4.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
      fin1 <= '0;
      fin2 <= '0;
      fin3 <= '0;
    end else begin
      tag1 <= tag0;
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
      fin1 <= fin0;
      fin2 <= fin1;
      fin3 <= fin2;
    end
  end

  always_ff @(posedge clk) begin
    x_d1 <= signed'(rdata);
    x_d2 <= x_d1;
    prod <= x_d2 * cos_q;
    if (tag4.valid) begin
      acc <= tag4.first ? ACCW'(prod) : acc + ACCW'(prod);
    end
    a16   <= acc_plus[ACCW-1:15];
    mprod <= a16 * signed'({1'b0, output_scale});
  end

  // rounding and saturation to Q15.16
  always_comb begin
    acc_plus = acc + ACCW'(16384);
    mplus    = mprod + MW'(32768);
    res      = mplus[MW-1:16];
    res_ext  = EW'(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= fin3.valid;
    end
  end

  always_ff @(posedge clk) begin
    component   <= fin3.k;
    last_of_run <= fin3.klast;
    if (res_ext > SAT_HI) begin
      coefficient <= SAT_HI[COEF_W-1:0];
      saturated   <= 1'b1;
    end else if (res_ext < SAT_LO) begin
      coefficient <= SAT_LO[COEF_W-1:0];
      saturated   <= 1'b1;
    end else begin
      coefficient <= res_ext[COEF_W-1:0];
      saturated   <= 1'b0;
    end
  end

endmodule

/* sim/tb_dct_highpass_residual_unit.sv */
// Self-checking bench for the DCT-II high-pass residual unit.
`timescale 1ns / 1ps

module tb_dct_highpass_residual_unit;
  import dcthp_pkg::*;

  localparam int unsigned NFRAMES      = MAX_FRAMES_DEF;
  localparam int unsigned COS_DEPTH    = COS_DEPTH_DEF;
  localparam int unsigned SW           = SAMPLE_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 170;
  localparam int unsigned STALL_LIMIT  = 20000;  // cycles with no request, result or write
  localparam int unsigned DRAIN_CYCLES = 16;     // settling margin once the unit is idle
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic [SW-1:0]    value;
  } sample_req_t;

  typedef struct packed {
    logic [DIM_W-1:0]         dim;
    logic [COMP_W-1:0]        k;
    logic signed [COEF_W-1:0] coef;
    logic                     sat;
    logic                     last;
  } coef_result_t;

  typedef struct packed {
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // DUT ports, inputs known from time zero
  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     start       = 1'b0;
  logic                     busy;
  logic [DIM_W-1:0]         dim_index   = '0;
  logic signed [SW-1:0]     sample      = '0;
  logic                     cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index   = '0;
  logic [CFG_DATA_W-1:0]    cfg_data    = '0;
  logic                     strobe;
  logic [DIM_W-1:0]         out_dim;
  logic [COMP_W-1:0]        component;
  logic signed [COEF_W-1:0] coefficient;
  logic                     saturated;
  logic                     last_of_run;

  // predictor state: register copies, series store, quarter-wave cosine
  logic [FRAME_W-1:0]       frames_cfg = FRAME_COUNT_RST;
  logic [LOW_W-1:0]         low_cfg    = LOW_COMP_RST;
  logic [DIM_W-1:0]         first_cfg  = FIRST_DIM_RST;
  logic [DIM_END_W-1:0]     end_cfg    = DIM_END_RST;
  logic [SCALE_W-1:0]       scale_cfg  = SCALE_RST;
  logic signed [SW-1:0]     series_ram [NFRAMES];
  int unsigned              fill_count = 0;
  int                       quarter_cos [COS_DEPTH];
  coef_result_t             coef_expected [$];

  // request feed and bookkeeping
  sample_req_t              pending_samples [$];
  reg_write_t               reg_writes [$];
  int unsigned              queued_total   = 0;
  int unsigned              accepted_total = 0;
  int unsigned              mismatch_count = 0;
  int unsigned              idle_cycles    = 0;
  int unsigned              gap_left       = 0;
  int unsigned              burst_left     = 1;

  dct_highpass_residual_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .dim_index   (dim_index),
    .sample      (sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .out_dim     (out_dim),
    .component   (component),
    .coefficient (coefficient),
    .saturated   (saturated),
    .last_of_run (last_of_run)
  );

  always #4 clk = ~clk;

  // Quarter-wave entry: Taylor series of cos in Q2.30, rounded to Q1.15.
  function automatic int quarter_wave_entry(longint unsigned i);
    longint unsigned ang, ang_sq, term, rounded, n;
    longint          acc;
    ang    = (i * PI_Q30 + COS_DEPTH) / (2 * COS_DEPTH);
    ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
    term   = 64'd1 << 30;
    acc    = longint'(term);
    for (n = 1; n <= 10; n++) begin
      term = ((term * ang_sq) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    rounded = ($unsigned(acc) + (64'd1 << 14)) >> 15;
    if (rounded > 32767) rounded = 32767;
    return int'(rounded);
  endfunction

  function automatic int quarter_at(int unsigned i);
    return (i >= COS_DEPTH) ? 0 : quarter_cos[i];
  endfunction

  // Phase k*(2t+1) mod 4N mapped onto the table through a rounded 1/N.
  function automatic int cos_at(int unsigned phase, int unsigned n);
    longint unsigned recip, pos;
    int unsigned     quad, ofs;
    recip = ((64'd1 << RECIP_BITS) + n / 2) / n;
    pos   = (64'(phase) * COS_DEPTH * recip + (64'd1 << (RECIP_BITS - 1))) >> RECIP_BITS;
    pos   = pos % (4 * COS_DEPTH);
    quad  = int'(pos / COS_DEPTH);
    ofs   = int'(pos % COS_DEPTH);
    case (quad)
      0: return quarter_at(ofs);
      1: return -quarter_at(COS_DEPTH - ofs);
      2: return -quarter_at(ofs);
      default: return quarter_at(COS_DEPTH - ofs);
    endcase
  endfunction

  // One accepted request: store the sample, and on a full series queue every
  // component from low_component up to N-1.
  function automatic void predict_coefs(logic [DIM_W-1:0] dim, logic signed [SW-1:0] value);
    int unsigned  n, k, t;
    longint       acc, a16, res;
    coef_result_t r;
    if (dim >= first_cfg && dim < end_cfg && dim < MAX_DIMS) begin
      n = (frames_cfg < 2) ? 2 : (frames_cfg > NFRAMES) ? NFRAMES : frames_cfg;
      series_ram[fill_count % NFRAMES] = value;
      fill_count++;
      if (fill_count >= n) begin
        fill_count = 0;
        for (k = low_cfg; k < n; k++) begin
          acc = 0;
          for (t = 0; t < n; t++)
            acc += longint'(series_ram[t]) * longint'(cos_at((k * (2 * t + 1)) % (4 * n), n));
          a16 = (acc + 64'sd16384) >>> 15;
          res = (a16 * longint'(scale_cfg) + 64'sd32768) >>> 16;
          r.sat = 1'b0;
          if (res > 64'sd2147483647) begin
            res   = 64'sd2147483647;
            r.sat = 1'b1;
          end
          if (res < -64'sd2147483648) begin
            res   = -64'sd2147483648;
            r.sat = 1'b1;
          end
          r.dim  = dim;
          r.k    = COMP_W'(k);
          r.coef = res[COEF_W-1:0];
          r.last = (k == n - 1);
          coef_expected.push_back(r);
        end
      end
    end
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return SW'($urandom());
    endcase
  endfunction

  task automatic queue_sample(logic [DIM_W-1:0] dim, logic [SW-1:0] value);
    sample_req_t s;
    s.dim   = dim;
    s.value = value;
    pending_samples.push_back(s);
    queued_total++;
  endtask

  // bits above the register width are don't-care; fill them half the time
  task automatic set_reg(cfg_reg_t idx, int unsigned value, int unsigned width);
    reg_write_t w;
    w.idx  = idx;
    w.data = CFG_DATA_W'(value);
    if (width < CFG_DATA_W && $urandom_range(0, 1) == 1)
      w.data = w.data | (CFG_DATA_W'($urandom()) << width);
    reg_writes.push_back(w);
  endtask

  // back-to-back writes; cfg_we drops only after the last one
  task automatic program_regs();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // idle = every queued request taken, busy low, nothing outstanding
  task automatic settle();
    do @(posedge clk);
    while (accepted_total != queued_total || start || busy || coef_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver: bursts of random length, random gaps between bursts.
  // start stays up across back-to-back requests.
  always @(posedge clk) begin
    sample_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        nxt = pending_samples.pop_front();
        start     <= 1'b1;
        dim_index <= nxt.dim;
        sample    <= nxt.value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 48) :
                                                     $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: tracks register writes, predicts on each accepted request,
  // checks every strobe against the oldest expected coefficient.
  always @(posedge clk) begin
    coef_result_t want;
    if (cfg_we || (start && !busy) || strobe) idle_cycles = 0;
    else idle_cycles++;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_COUNT:  frames_cfg = cfg_data[FRAME_W-1:0];
          REG_LOW_COMP:     low_cfg    = cfg_data[LOW_W-1:0];
          REG_FIRST_DIM:    first_cfg  = cfg_data[DIM_W-1:0];
          REG_DIM_END:      end_cfg    = cfg_data[DIM_END_W-1:0];
          REG_OUTPUT_SCALE: scale_cfg  = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_coefs(dim_index, sample);
        accepted_total++;
      end
      if (strobe) begin
        if (coef_expected.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("unexpected result: dim %0d k %0d coef %0d sat %0b last %0b",
                     out_dim, component, coefficient, saturated, last_of_run);
          mismatch_count++;
        end else begin
          want = coef_expected.pop_front();
          if (out_dim !== want.dim || component !== want.k || coefficient !== want.coef ||
              saturated !== want.sat || last_of_run !== want.last) begin
            if (mismatch_count < REPORT_MAX)
              $display("mismatch dim/k/coef/sat/last: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                       want.dim, want.k, want.coef, want.sat, want.last,
                       out_dim, component, coefficient, saturated, last_of_run);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog: no progress for too long
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned i, count, ph, raw_n, n, low, first, dend, scale;
    int unsigned win_lo, win_hi;
    logic [DIM_W-1:0] dim;

    for (i = 0; i < COS_DEPTH; i++) quarter_cos[i] = quarter_wave_entry(i);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // N=2, full scale: both rails saturate; dims at both ends; alternating bits
    set_reg(REG_FRAME_COUNT, 2, FRAME_W);
    set_reg(REG_LOW_COMP, 0, LOW_W);
    set_reg(REG_FIRST_DIM, 0, DIM_W);
    set_reg(REG_DIM_END, 64, DIM_END_W);
    set_reg(REG_OUTPUT_SCALE, 24'hFFFFFF, SCALE_W);
    program_regs();
    queue_sample(0, 24'h7FFFFF);
    queue_sample(63, 24'h7FFFFF);
    queue_sample(63, 24'h800000);
    queue_sample(0, 24'h800000);
    queue_sample(21, 24'h555555);
    queue_sample(42, 24'hAAAAAA);
    settle();

    // dimension window [5,10): edges on both sides get dropped
    set_reg(REG_FIRST_DIM, 5, DIM_W);
    set_reg(REG_DIM_END, 10, DIM_END_W);
    set_reg(REG_OUTPUT_SCALE, 24'h010000, SCALE_W);
    program_regs();
    queue_sample(4, 24'h123456);
    queue_sample(5, 24'h010000);
    queue_sample(10, 24'h7FFFFF);
    queue_sample(9, 24'hFF0000);
    queue_sample(63, 24'h000001);
    queue_sample(0, 24'h800000);
    settle();

    // low component at N: series completes with no result
    set_reg(REG_LOW_COMP, 2, LOW_W);
    program_regs();
    queue_sample(6, 24'h000100);
    queue_sample(7, 24'hFFFF00);
    settle();

    // only the top component
    set_reg(REG_LOW_COMP, 1, LOW_W);
    program_regs();
    queue_sample(8, 24'h0ABCDE);
    queue_sample(5, 24'hF54321);
    settle();

    // frame count below range clamps to 2
    set_reg(REG_FRAME_COUNT, 0, FRAME_W);
    program_regs();
    queue_sample(9, 24'h7FFFFF);
    queue_sample(9, 24'h000000);
    settle();

    // count left above N by a register change: next request completes it
    set_reg(REG_FRAME_COUNT, 4, FRAME_W);
    set_reg(REG_LOW_COMP, 0, LOW_W);
    program_regs();
    queue_sample(5, 24'h100000);
    queue_sample(6, 24'hF00000);
    queue_sample(7, 24'h080000);
    settle();
    set_reg(REG_FRAME_COUNT, 2, FRAME_W);
    program_regs();
    queue_sample(8, 24'h040000);
    settle();

    // --- random phases ---
    // first phase: frame count above range (clamps to 64), every component
    ph = 0;
    while (queued_total < RANDOM_ITEMS) begin
      if (ph == 0) begin
        raw_n = 127;
        low   = 0;
        first = 0;
        dend  = 64;
        scale = $urandom_range(1024, 131072);
      end else begin
        case ($urandom_range(0, 9))
          0: raw_n = $urandom_range(9, 20);
          1: raw_n = $urandom_range(0, 1);
          default: raw_n = $urandom_range(2, 8);
        endcase
        n = (raw_n < 2) ? 2 : raw_n;
        case ($urandom_range(0, 7))
          0: low = $urandom_range(n, 63);   // nothing emitted
          1: low = n - 1;
          default: low = $urandom_range(0, n / 2);
        endcase
        case ($urandom_range(0, 7))
          0: begin
            first = 0;
            dend  = $urandom_range(65, 127);
          end
          1: begin
            first = 63;
            dend  = 64;
          end
          2: begin
            first = $urandom_range(0, 40);
            dend  = first + $urandom_range(1, 23);
          end
          3: begin                         // empty window, noise only
            first = $urandom_range(1, 63);
            dend  = $urandom_range(0, first);
          end
          default: begin
            first = 0;
            dend  = 64;
          end
        endcase
        case ($urandom_range(0, 5))
          0: scale = 0;
          1: scale = 24'hFFFFFF;
          2: scale = $urandom_range(0, 24'hFFFFFF);
          default: scale = $urandom_range(1024, 131072);
        endcase
      end
      n = (raw_n < 2) ? 2 : (raw_n > NFRAMES) ? NFRAMES : raw_n;

      set_reg(REG_FRAME_COUNT, raw_n, FRAME_W);
      set_reg(REG_LOW_COMP, low, LOW_W);
      set_reg(REG_FIRST_DIM, first, DIM_W);
      set_reg(REG_DIM_END, dend, DIM_END_W);
      set_reg(REG_OUTPUT_SCALE, scale, SCALE_W);
      program_regs();

      win_lo = first;
      win_hi = (dend > MAX_DIMS) ? MAX_DIMS : dend;
      if (win_lo < win_hi) begin
        count = ((n >= 32) ? 1 : $urandom_range(1, 4)) * n;
        // sometimes leave a partial series for the next setting
        if ($urandom_range(0, 3) == 0) count += $urandom_range(1, n - 1);
      end else begin
        count = 6;
      end

      // mostly in-window series, with stray dims mixed in
      for (i = 0; i < count; i++) begin
        if (win_lo >= win_hi || $urandom_range(0, 4) == 0) begin
          dim = DIM_W'($urandom_range(0, 63));
          queue_sample(dim, pick_sample());
        end
        if (win_lo < win_hi) begin
          queue_sample(DIM_W'($urandom_range(win_lo, win_hi - 1)), pick_sample());
        end
      end
      settle();
      ph++;
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
